[src/lswc_pkg.sv]
// Shared types, constants and the per-region-code clip program table.
package lswc_pkg;

	localparam int CW = 16;                    // coordinate width
	localparam int PW = 2 * CW + 2;            // product of two CW+1 bit differences
	localparam int DIV_STEPS = PW / 2;         // two quotient bits per cycle
	localparam int QDEPTH = 2;                 // front-to-back queue depth
	localparam int NSTEP = 6;                  // longest clip program

	typedef logic signed [CW-1:0] coord_t;

	typedef enum logic [1:0] {
		REG_LEFT,
		REG_TOP,
		REG_RIGHT,
		REG_BOTTOM
	} reg_idx_t;

	// region code bits of one endpoint
	localparam logic [3:0] RC_BOTTOM = 4'h8;
	localparam logic [3:0] RC_TOP    = 4'h4;
	localparam logic [3:0] RC_RIGHT  = 4'h2;
	localparam logic [3:0] RC_LEFT   = 4'h1;

	typedef struct packed {
		coord_t left;
		coord_t top;
		coord_t right;
		coord_t bottom;
	} win_t;

	typedef struct packed {
		coord_t ey;
		coord_t ex;
		coord_t sy;
		coord_t sx;
	} seg_t;

	typedef struct packed {
		logic [7:0] code;
		seg_t       seg;
	} item_t;

	typedef enum logic [2:0] {
		K_END,   // done, visible
		K_FAIL,  // done, rejected
		K_OP,    // intersect
		K_COP,   // intersect if the endpoint lies beyond the edge
		K_REJ    // reject if the endpoint lies beyond the edge
	} kind_t;

	typedef enum logic {
		EP_START,
		EP_END
	} ep_t;

	typedef enum logic [1:0] {
		S_LEFT,
		S_RIGHT,
		S_TOP,
		S_BOTTOM
	} side_t;

	typedef struct packed {
		kind_t kind;
		ep_t   ep;
		side_t side;
	} step_t;

	typedef step_t [NSTEP-1:0] prog_t;

	function automatic logic [3:0] region(coord_t x, coord_t y, win_t w);
		logic [3:0] c;
		c = 4'h0;
		if (y > w.bottom) c = c | RC_BOTTOM;
		else if (y < w.top) c = c | RC_TOP;
		if (x > w.right) c = c | RC_RIGHT;
		else if (x < w.left) c = c | RC_LEFT;
		return c;
	endfunction

	function automatic step_t op(ep_t e, side_t s);
		return '{kind: K_OP, ep: e, side: s};
	endfunction

	function automatic step_t cop(ep_t e, side_t s);
		return '{kind: K_COP, ep: e, side: s};
	endfunction

	function automatic step_t rej(ep_t e, side_t s);
		return '{kind: K_REJ, ep: e, side: s};
	endfunction

	// Step list for each region code; unused slots end the program.
	function automatic prog_t clip_prog(logic [7:0] code);
		prog_t p;
		for (int i = 0; i < NSTEP; i++) p[i] = '{kind: K_END, ep: EP_START, side: S_LEFT};
		case (code)
			8'h00: ;
			8'h01: p[0] = op(EP_END, S_LEFT);
			8'h02: p[0] = op(EP_END, S_RIGHT);
			8'h04: p[0] = op(EP_END, S_TOP);
			8'h05: begin p[0] = op(EP_END, S_LEFT); p[1] = cop(EP_END, S_TOP); end
			8'h06: begin p[0] = op(EP_END, S_RIGHT); p[1] = cop(EP_END, S_TOP); end
			8'h08: p[0] = op(EP_END, S_BOTTOM);
			8'h09: begin p[0] = op(EP_END, S_LEFT); p[1] = cop(EP_END, S_BOTTOM); end
			8'h0A: begin p[0] = op(EP_END, S_RIGHT); p[1] = cop(EP_END, S_BOTTOM); end
			8'h10: p[0] = op(EP_START, S_LEFT);
			8'h12: begin p[0] = op(EP_START, S_LEFT); p[1] = op(EP_END, S_RIGHT); end
			8'h14: begin
				p[0] = op(EP_START, S_LEFT); p[1] = rej(EP_START, S_TOP);
				p[2] = op(EP_END, S_TOP);
			end
			8'h16: begin
				p[0] = op(EP_START, S_LEFT); p[1] = rej(EP_START, S_TOP);
				p[2] = op(EP_END, S_TOP); p[3] = cop(EP_END, S_RIGHT);
			end
			8'h18: begin
				p[0] = op(EP_START, S_LEFT); p[1] = rej(EP_START, S_BOTTOM);
				p[2] = op(EP_END, S_BOTTOM);
			end
			8'h1A: begin
				p[0] = op(EP_START, S_LEFT); p[1] = rej(EP_START, S_BOTTOM);
				p[2] = op(EP_END, S_BOTTOM); p[3] = cop(EP_END, S_RIGHT);
			end
			8'h20: p[0] = op(EP_START, S_RIGHT);
			8'h21: begin p[0] = op(EP_START, S_RIGHT); p[1] = op(EP_END, S_LEFT); end
			8'h24: begin
				p[0] = op(EP_START, S_RIGHT); p[1] = rej(EP_START, S_TOP);
				p[2] = op(EP_END, S_TOP);
			end
			8'h25: begin
				p[0] = op(EP_START, S_RIGHT); p[1] = rej(EP_START, S_TOP);
				p[2] = op(EP_END, S_TOP); p[3] = cop(EP_END, S_LEFT);
			end
			8'h28: begin
				p[0] = op(EP_START, S_RIGHT); p[1] = rej(EP_START, S_BOTTOM);
				p[2] = op(EP_END, S_BOTTOM);
			end
			8'h29: begin
				p[0] = op(EP_START, S_RIGHT); p[1] = rej(EP_START, S_BOTTOM);
				p[2] = op(EP_END, S_BOTTOM); p[3] = cop(EP_END, S_LEFT);
			end
			8'h40: p[0] = op(EP_START, S_TOP);
			8'h41: begin
				p[0] = op(EP_START, S_TOP); p[1] = rej(EP_START, S_LEFT);
				p[2] = op(EP_END, S_LEFT); p[3] = cop(EP_END, S_TOP);
			end
			8'h42: begin
				p[0] = op(EP_START, S_TOP); p[1] = rej(EP_START, S_RIGHT);
				p[2] = op(EP_END, S_RIGHT);
			end
			8'h48: begin p[0] = op(EP_START, S_TOP); p[1] = op(EP_END, S_BOTTOM); end
			8'h49: begin
				p[0] = op(EP_START, S_TOP); p[1] = rej(EP_START, S_LEFT);
				p[2] = op(EP_END, S_LEFT); p[3] = cop(EP_END, S_BOTTOM);
			end
			8'h4A: begin
				p[0] = op(EP_START, S_TOP); p[1] = rej(EP_START, S_RIGHT);
				p[2] = op(EP_END, S_RIGHT); p[3] = cop(EP_END, S_BOTTOM);
			end
			8'h50: begin p[0] = op(EP_START, S_LEFT); p[1] = cop(EP_START, S_TOP); end
			8'h52: begin
				p[0] = op(EP_END, S_RIGHT); p[1] = rej(EP_END, S_TOP);
				p[2] = op(EP_START, S_TOP); p[3] = cop(EP_START, S_LEFT);
			end
			8'h58: begin
				p[0] = op(EP_END, S_BOTTOM); p[1] = rej(EP_END, S_LEFT);
				p[2] = op(EP_START, S_TOP); p[3] = cop(EP_START, S_LEFT);
			end
			8'h5A: begin
				p[0] = op(EP_START, S_LEFT); p[1] = rej(EP_START, S_BOTTOM);
				p[2] = op(EP_END, S_RIGHT); p[3] = rej(EP_END, S_TOP);
				p[4] = cop(EP_START, S_TOP); p[5] = cop(EP_END, S_BOTTOM);
			end
			8'h60: begin p[0] = op(EP_START, S_RIGHT); p[1] = cop(EP_START, S_TOP); end
			8'h61: begin
				p[0] = op(EP_END, S_LEFT); p[1] = rej(EP_END, S_TOP);
				p[2] = op(EP_START, S_TOP); p[3] = cop(EP_START, S_RIGHT);
			end
			8'h68: begin
				p[0] = op(EP_END, S_BOTTOM); p[1] = rej(EP_END, S_RIGHT);
				p[2] = op(EP_START, S_RIGHT); p[3] = cop(EP_START, S_TOP);
			end
			8'h69: begin
				p[0] = op(EP_END, S_LEFT); p[1] = rej(EP_END, S_TOP);
				p[2] = op(EP_START, S_RIGHT); p[3] = rej(EP_START, S_BOTTOM);
				p[4] = cop(EP_END, S_BOTTOM); p[5] = cop(EP_START, S_TOP);
			end
			8'h80: p[0] = op(EP_START, S_BOTTOM);
			8'h81: begin
				p[0] = op(EP_START, S_BOTTOM); p[1] = rej(EP_START, S_LEFT);
				p[2] = op(EP_END, S_LEFT);
			end
			8'h82: begin
				p[0] = op(EP_START, S_BOTTOM); p[1] = rej(EP_START, S_RIGHT);
				p[2] = op(EP_END, S_RIGHT);
			end
			8'h84: begin p[0] = op(EP_START, S_BOTTOM); p[1] = op(EP_END, S_TOP); end
			8'h85: begin
				p[0] = op(EP_START, S_BOTTOM); p[1] = rej(EP_START, S_LEFT);
				p[2] = op(EP_END, S_LEFT); p[3] = cop(EP_END, S_TOP);
			end
			8'h86: begin
				p[0] = op(EP_START, S_BOTTOM); p[1] = rej(EP_START, S_RIGHT);
				p[2] = op(EP_END, S_RIGHT); p[3] = cop(EP_END, S_TOP);
			end
			8'h90: begin p[0] = op(EP_START, S_LEFT); p[1] = cop(EP_START, S_BOTTOM); end
			8'h92: begin
				p[0] = op(EP_END, S_RIGHT); p[1] = rej(EP_END, S_BOTTOM);
				p[2] = op(EP_START, S_BOTTOM); p[3] = cop(EP_START, S_LEFT);
			end
			8'h94: begin
				p[0] = op(EP_END, S_TOP); p[1] = rej(EP_END, S_LEFT);
				p[2] = op(EP_START, S_LEFT); p[3] = cop(EP_START, S_BOTTOM);
			end
			8'h96: begin
				p[0] = op(EP_START, S_LEFT); p[1] = rej(EP_START, S_TOP);
				p[2] = op(EP_END, S_RIGHT); p[3] = rej(EP_END, S_BOTTOM);
				p[4] = cop(EP_START, S_BOTTOM); p[5] = cop(EP_END, S_TOP);
			end
			8'hA0: begin p[0] = op(EP_START, S_RIGHT); p[1] = cop(EP_START, S_BOTTOM); end
			8'hA1: begin
				p[0] = op(EP_END, S_LEFT); p[1] = rej(EP_END, S_BOTTOM);
				p[2] = op(EP_START, S_BOTTOM); p[3] = cop(EP_START, S_RIGHT);
			end
			8'hA4: begin
				p[0] = op(EP_END, S_TOP); p[1] = rej(EP_END, S_RIGHT);
				p[2] = op(EP_START, S_RIGHT); p[3] = cop(EP_START, S_BOTTOM);
			end
			8'hA5: begin
				p[0] = op(EP_END, S_LEFT); p[1] = rej(EP_END, S_BOTTOM);
				p[2] = op(EP_START, S_RIGHT); p[3] = rej(EP_START, S_TOP);
				p[4] = cop(EP_END, S_TOP); p[5] = cop(EP_START, S_BOTTOM);
			end
			default: p[0] = '{kind: K_FAIL, ep: EP_START, side: S_LEFT};
		endcase
		return p;
	endfunction

endpackage

[src/lswc_front.sv]
// Front end: unpacks an input beat and builds its 8-bit region code.
module lswc_front (
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [63:0]          s_axis_tdata,
	input  lswc_pkg::win_t       win,
	input  logic                 q_full,
	output logic                 q_push,
	output lswc_pkg::item_t      q_item
);
	import lswc_pkg::*;

	seg_t seg;

	assign seg.sx = s_axis_tdata[CW-1:0];
	assign seg.sy = s_axis_tdata[2*CW-1:CW];
	assign seg.ex = s_axis_tdata[3*CW-1:2*CW];
	assign seg.ey = s_axis_tdata[4*CW-1:3*CW];

	assign s_axis_tready = !q_full;
	assign q_push        = s_axis_tvalid && !q_full;
	assign q_item.seg    = seg;
	assign q_item.code   = {region(seg.sx, seg.sy, win), region(seg.ex, seg.ey, win)};

endmodule

[src/lswc_queue.sv]
// Small FIFO between the classifier and the clip sequencer.
module lswc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lswc_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output lswc_pkg::item_t pop_item
);
	import lswc_pkg::*;

	localparam int AW = $clog2(QDEPTH);

	item_t          mem_q [QDEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [AW:0]    cnt_q;

	assign full     = (cnt_q == (AW+1)'(QDEPTH));
	assign valid    = (cnt_q != '0);
	assign pop_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[src/lswc_back.sv]
// Back end: runs the clip program of one segment, one intersection at a time.
module lswc_back (
	input  logic            clk,
	input  logic            arst_n,
	input  lswc_pkg::win_t  win,
	input  logic            q_valid,
	input  lswc_pkg::item_t q_item,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output lswc_pkg::seg_t  out_seg,
	output logic            out_vis
);
	import lswc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_MUL,
		ST_DIV,
		ST_WB,
		ST_DONE
	} state_t;

	typedef logic signed [CW:0] diff_t;
	localparam int CNTW = $clog2(DIV_STEPS);

	state_t            state_q;
	logic [2:0]        idx_q;
	prog_t             prog_q;
	seg_t              seg_q;
	seg_t              orig_q;
	logic              vis_q;
	logic              out_valid_q;
	seg_t              out_seg_q;
	logic              out_vis_q;
	ep_t               ep_q;
	side_t             side_q;
	coord_t            base_q;
	diff_t             a_q;
	diff_t             b_q;
	diff_t             d_q;
	logic              neg_q;
	logic              dz_q;
	logic [PW-1:0]     dvd_q;
	logic [CW:0]       dsr_q;
	logic [CW+1:0]     rem_q;
	logic [CNTW-1:0]   cnt_q;

	step_t             cur;
	coord_t            nx, ny, fx, fy, ev, wev;
	logic              xaxis, cond;
	diff_t             span, num, den;
	logic signed [PW-1:0] prod;
	logic [PW-1:0]     dvd_n;
	logic [CW+1:0]     rem_n;
	logic [PW:0]       qx;
	logic signed [PW:0] sum;
	coord_t            satv;
	logic              out_load;

	assign out_valid = out_valid_q;
	assign out_seg   = out_seg_q;
	assign out_vis   = out_vis_q;
	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	function automatic coord_t side_val(side_t s, win_t w);
		case (s)
			S_LEFT:   return w.left;
			S_RIGHT:  return w.right;
			S_TOP:    return w.top;
			S_BOTTOM: return w.bottom;
			default:  return w.left;
		endcase
	endfunction

	// step decode: near endpoint moves, far endpoint anchors the line
	always_comb begin
		cur = (idx_q < 3'(NSTEP)) ? prog_q[idx_q] :
			step_t'{kind: K_END, ep: EP_START, side: S_LEFT};
		nx = (cur.ep == EP_START) ? seg_q.sx : seg_q.ex;
		ny = (cur.ep == EP_START) ? seg_q.sy : seg_q.ey;
		fx = (cur.ep == EP_START) ? seg_q.ex : seg_q.sx;
		fy = (cur.ep == EP_START) ? seg_q.ey : seg_q.sy;
		ev = side_val(cur.side, win);
		xaxis = (cur.side == S_LEFT) || (cur.side == S_RIGHT);
		case (cur.side)
			S_LEFT:   cond = nx < ev;
			S_RIGHT:  cond = nx > ev;
			S_TOP:    cond = ny < ev;
			S_BOTTOM: cond = ny > ev;
			default:  cond = 1'b0;
		endcase
		if (xaxis) begin
			span = diff_t'(fy) - diff_t'(ny);
			num  = diff_t'(ev) - diff_t'(nx);
			den  = diff_t'(fx) - diff_t'(nx);
		end else begin
			span = diff_t'(fx) - diff_t'(nx);
			num  = diff_t'(ev) - diff_t'(ny);
			den  = diff_t'(fy) - diff_t'(ny);
		end
	end

	assign prod = PW'(a_q) * PW'(b_q);

	// two restoring-division steps per cycle
	always_comb begin
		logic [CW+1:0] r;
		logic [PW-1:0] d;
		r = rem_q;
		d = dvd_q;
		for (int i = 0; i < 2; i++) begin
			r = {r[CW:0], d[PW-1]};
			d = {d[PW-2:0], 1'b0};
			if (r >= {1'b0, dsr_q}) begin
				r = r - {1'b0, dsr_q};
				d[0] = 1'b1;
			end
		end
		rem_n = r;
		dvd_n = d;
	end

	// write-back: add the signed quotient and saturate
	always_comb begin
		qx  = dz_q ? '0 : {1'b0, dvd_q};
		sum = (PW+1)'(base_q) + (neg_q ? -$signed(qx) : $signed(qx));
		if (sum[PW:CW-1] == '0 || sum[PW:CW-1] == '1) satv = sum[CW-1:0];
		else if (sum[PW]) satv = {1'b1, {(CW-1){1'b0}}};
		else satv = {1'b0, {(CW-1){1'b1}}};
		wev = side_val(side_q, win);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						prog_q  <= clip_prog(q_item.code);
						seg_q   <= q_item.seg;
						orig_q  <= q_item.seg;
						idx_q   <= '0;
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					case (cur.kind)
						K_END: begin
							vis_q   <= 1'b1;
							state_q <= ST_DONE;
						end
						K_REJ: begin
							if (cond) begin
								vis_q   <= 1'b0;
								state_q <= ST_DONE;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end
						K_OP, K_COP: begin
							if (cur.kind == K_OP || cond) begin
								ep_q    <= cur.ep;
								side_q  <= cur.side;
								base_q  <= xaxis ? ny : nx;
								a_q     <= span;
								b_q     <= num;
								d_q     <= den;
								state_q <= ST_MUL;
							end else begin
								idx_q <= idx_q + 1'b1;
							end
						end
						default: begin
							vis_q   <= 1'b0;
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_MUL: begin
					neg_q   <= prod[PW-1] ^ d_q[CW];
					dvd_q   <= prod[PW-1] ? PW'(-prod) : PW'(prod);
					dsr_q   <= d_q[CW] ? (CW+1)'(-d_q) : (CW+1)'(d_q);
					dz_q    <= (d_q == '0);
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					dvd_q <= dvd_n;
					rem_q <= rem_n;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNTW'(DIV_STEPS - 1)) state_q <= ST_WB;
				end
				ST_WB: begin
					if (side_q == S_LEFT || side_q == S_RIGHT) begin
						if (ep_q == EP_START) begin
							seg_q.sx <= wev;
							seg_q.sy <= satv;
						end else begin
							seg_q.ex <= wev;
							seg_q.ey <= satv;
						end
					end else begin
						if (ep_q == EP_START) begin
							seg_q.sx <= satv;
							seg_q.sy <= wev;
						end else begin
							seg_q.ex <= satv;
							seg_q.ey <= wev;
						end
					end
					idx_q   <= idx_q + 1'b1;
					state_q <= ST_STEP;
				end
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_seg_q <= vis_q ? seg_q : orig_q;
			out_vis_q <= vis_q;
		end
	end

endmodule

[src/line_segment_window_clipper_core.sv]
// Top level: 2-D line segment clipper against a configurable window.
//
// Input stream (s_axis): one beat per segment, start and end points as signed
// 16-bit pixels. Output stream (m_axis): one beat per segment, the clipped
// endpoints in tdata and the visible flag in tuser. A rejected segment comes
// out with visible low and its input endpoints unchanged.
// Config: cfg_we writes cfg_data into window register cfg_index (left, top,
// right, bottom) at the clock edge; write only while the block is empty.
//
// Flow: the front end takes a beat in the cycle it arrives
// whenever the two-entry queue has room, so input is taken back to back
// while the sequencer works. The sequencer handles one segment at a time:
// it loads the segment, runs each program step that is a test, and for each
// edge intersection does operand setup, multiply, radix-4 division and
// write-back, then hands off the result; one shared multiply/divide unit
// serves every intersection.
// Reset: clears the queue, the sequencer and the output valid; the window
// returns to 0,0 - 319,199. Output stall: the result holds in the output
// register, the sequencer waits in its done state, and the queue fills.
module line_segment_window_clipper_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // start_x, start_y, end_x, end_y
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // clipped_start_x, clipped_start_y,
	                                    // clipped_end_x, clipped_end_y
	output logic        m_axis_tuser,   // visible
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import lswc_pkg::*;

	win_t   win_q;
	logic   q_full, q_push, q_pop, q_valid;
	item_t  push_item, pop_item;
	seg_t   out_seg;

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.left   <= CW'(0);
			win_q.top    <= CW'(0);
			win_q.right  <= CW'(319);
			win_q.bottom <= CW'(199);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_LEFT:   win_q.left   <= cfg_data;
				REG_TOP:    win_q.top    <= cfg_data;
				REG_RIGHT:  win_q.right  <= cfg_data;
				REG_BOTTOM: win_q.bottom <= cfg_data;
				default: ;
			endcase
		end
	end

	lswc_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.win           (win_q),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (push_item)
	);

	lswc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_item  (pop_item)
	);

	lswc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.win       (win_q),
		.q_valid   (q_valid),
		.q_item    (pop_item),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_seg   (out_seg),
		.out_vis   (m_axis_tuser)
	);

	assign m_axis_tdata = {out_seg.ey, out_seg.ex, out_seg.sy, out_seg.sx};

endmodule

[src/lswc_chk.sv]
// Port-level checker for the clipper, bound to the top level.
module lswc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic        m_axis_tuser
);
	import lswc_pkg::*;

	logic [2:0] pend_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= '0;
		else if (in_acc && !out_acc) pend_q <= pend_q + 1'b1;
		else if (out_acc && !in_acc) pend_q <= pend_q - 1'b1;
	end

	a_rst_idle: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pend_q != '0)
		else $error("result with no segment outstanding");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 3'(QDEPTH + 2) |-> !s_axis_tready)
		else $error("input taken beyond internal capacity");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind line_segment_window_clipper_core lswc_chk u_lswc_chk (.*);
